// ----- rtl/wbss_pkg.sv -----
// wbss_pkg: shared constants, register indexes and stage types for the
// wildcard byte signature scanner; no dependencies
package wbss_pkg;

  localparam int MAX_PATTERN_BYTES = 32;
  localparam int ADDR_BITS         = 48;
  localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W             = $clog2(MAX_PATTERN_BYTES);
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int WORD_BYTES        = CFG_DATA_W / 8;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_0      = 3'd0,
    CFG_PATTERN_1      = 3'd1,
    CFG_PATTERN_2      = 3'd2,
    CFG_PATTERN_3      = 3'd3,
    CFG_CARE_MASK      = 3'd4,
    CFG_PATTERN_LENGTH = 3'd5
  } cfg_idx_t;

  // pattern lined up with window positions, position 0 newest
  typedef struct packed {
    byte_t [MAX_PATTERN_BYTES-1:0] exp_byte;
    logic  [MAX_PATTERN_BYTES-1:0] care;
    logic  [LEN_W-1:0]             len;
  } align_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic                 scan_first;
    logic [LEN_W-1:0]     fill;
  } stage_t;

endpackage

// ----- rtl/wbss_cfg.sv -----
// wbss_cfg: configuration registers and pattern alignment to window positions
// depends on wbss_pkg
module wbss_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [wbss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wbss_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output wbss_pkg::align_t                      align
);

  logic [wbss_pkg::MAX_PATTERN_BYTES*8-1:0] pat_r, pat_nxt;
  logic [wbss_pkg::MAX_PATTERN_BYTES-1:0]   care_r, care_nxt;
  logic [wbss_pkg::LEN_W-1:0]               len_r, len_nxt;
  logic [wbss_pkg::LEN_W-1:0]               eff_len;
  wbss_pkg::align_t                         align_r, align_nxt;

  always_comb begin
    pat_nxt  = pat_r;
    care_nxt = care_r;
    len_nxt  = len_r;
    if (cfg_we) begin
      case (wbss_pkg::cfg_idx_t'(cfg_index))
        wbss_pkg::CFG_PATTERN_0: pat_nxt[0*wbss_pkg::CFG_DATA_W +: wbss_pkg::CFG_DATA_W] = cfg_wdata;
        wbss_pkg::CFG_PATTERN_1: pat_nxt[1*wbss_pkg::CFG_DATA_W +: wbss_pkg::CFG_DATA_W] = cfg_wdata;
        wbss_pkg::CFG_PATTERN_2: pat_nxt[2*wbss_pkg::CFG_DATA_W +: wbss_pkg::CFG_DATA_W] = cfg_wdata;
        wbss_pkg::CFG_PATTERN_3: pat_nxt[3*wbss_pkg::CFG_DATA_W +: wbss_pkg::CFG_DATA_W] = cfg_wdata;
        wbss_pkg::CFG_CARE_MASK: care_nxt = cfg_wdata[wbss_pkg::MAX_PATTERN_BYTES-1:0];
        wbss_pkg::CFG_PATTERN_LENGTH: len_nxt = cfg_wdata[wbss_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      care_r <= '0;
      len_r  <= wbss_pkg::LEN_W'(1);
    end else begin
      pat_r  <= pat_nxt;
      care_r <= care_nxt;
      len_r  <= len_nxt;
    end
  end

  // zero length acts as one, oversize saturates
  always_comb begin
    if (len_r == '0)
      eff_len = wbss_pkg::LEN_W'(1);
    else if (len_r > wbss_pkg::LEN_W'(wbss_pkg::MAX_PATTERN_BYTES))
      eff_len = wbss_pkg::LEN_W'(wbss_pkg::MAX_PATTERN_BYTES);
    else
      eff_len = len_r;
  end

  // window position j compares against pattern byte len-1-j
  always_comb begin
    logic [wbss_pkg::IDX_W-1:0] k;
    align_nxt.len = eff_len;
    for (int j = 0; j < wbss_pkg::MAX_PATTERN_BYTES; j++) begin
      k = wbss_pkg::IDX_W'(eff_len - wbss_pkg::LEN_W'(1) - wbss_pkg::LEN_W'(j));
      align_nxt.exp_byte[j] = pat_r[k*8 +: 8];
      align_nxt.care[j]     = care_r[k] && (wbss_pkg::LEN_W'(j) < eff_len);
    end
  end

  always_ff @(posedge clk) begin
    align_r <= align_nxt;
  end

  assign align = align_r;

endmodule

// ----- rtl/wbss_window.sv -----
// wbss_window: input register stage holding the sliding byte window and fill count
// depends on wbss_pkg
module wbss_window (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             in_data_byte,
  input  logic [wbss_pkg::ADDR_BITS-1:0]         in_byte_address,
  input  logic                                   in_region_first,
  input  logic                                   in_scan_first,
  input  logic                                   advance,
  output logic                                   s1_valid,
  output wbss_pkg::stage_t                       s1_stage,
  output wbss_pkg::byte_t [wbss_pkg::MAX_PATTERN_BYTES-1:0] s1_window
);

  logic                                              valid_r, valid_nxt;
  wbss_pkg::byte_t [wbss_pkg::MAX_PATTERN_BYTES-1:0] win_r, win_nxt;
  logic [wbss_pkg::LEN_W-1:0]                        fill_r, fill_nxt;
  logic [wbss_pkg::ADDR_BITS-1:0]                    addr_r;
  logic                                              scan_r;
  logic                                              accept;

  assign in_ready = !valid_r || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    if (accept) begin
      valid_nxt = 1'b1;
      win_nxt   = {win_r[wbss_pkg::MAX_PATTERN_BYTES-2:0], in_data_byte};
      if (in_region_first)
        fill_nxt = wbss_pkg::LEN_W'(1);
      else if (fill_r < wbss_pkg::LEN_W'(wbss_pkg::MAX_PATTERN_BYTES))
        fill_nxt = fill_r + wbss_pkg::LEN_W'(1);
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      win_r   <= '0;
      fill_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_byte_address;
      scan_r <= in_scan_first;
    end
  end

  assign s1_valid            = valid_r;
  assign s1_window           = win_r;
  assign s1_stage.addr       = addr_r;
  assign s1_stage.scan_first = scan_r;
  assign s1_stage.fill       = fill_r;

endmodule

// ----- rtl/wbss_match.sv -----
// wbss_match: parallel window compare, found latch and result register
// depends on wbss_pkg
module wbss_match (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   s1_valid,
  input  wbss_pkg::stage_t                       s1_stage,
  input  wbss_pkg::byte_t [wbss_pkg::MAX_PATTERN_BYTES-1:0] s1_window,
  input  wbss_pkg::align_t                       align,
  output logic                                   advance,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_window_match,
  output logic                                   out_first_hit,
  output logic [wbss_pkg::ADDR_BITS-1:0]         out_hit_address
);

  logic                                   valid_r, valid_nxt;
  logic                                   found_r, found_nxt;
  logic                                   match_r, first_r;
  logic [wbss_pkg::ADDR_BITS-1:0]         hit_addr_r;
  logic [wbss_pkg::MAX_PATTERN_BYTES-1:0] pos_ok;
  logic                                   match;
  logic                                   found_prev;
  logic                                   load;

  assign advance = !valid_r || out_ready;
  assign load    = s1_valid && advance;

  always_comb begin
    for (int j = 0; j < wbss_pkg::MAX_PATTERN_BYTES; j++)
      pos_ok[j] = !align.care[j] || (s1_window[j] == align.exp_byte[j]);
  end

  assign match      = (s1_stage.fill >= align.len) && (&pos_ok);
  assign found_prev = found_r && !s1_stage.scan_first;

  always_comb begin
    valid_nxt = valid_r;
    found_nxt = found_r;
    if (load) begin
      valid_nxt = 1'b1;
      found_nxt = found_prev || match;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      match_r    <= match;
      first_r    <= match && !found_prev;
      hit_addr_r <= match ? (s1_stage.addr + wbss_pkg::ADDR_BITS'(1)
                             - wbss_pkg::ADDR_BITS'(align.len)) : '0;
    end
  end

  assign out_valid        = valid_r;
  assign out_window_match = match_r;
  assign out_first_hit    = first_r;
  assign out_hit_address  = hit_addr_r;

endmodule

// ----- rtl/wildcard_byte_signature_scanner_top.sv -----
// wildcard_byte_signature_scanner_top: two register stages, window then compare
// items are registered in the window stage, then the compare stage; with out_ready high,
// throughput 1 item per cycle, both stages refill on the edge they hand over
// synchronous active-low reset clears config to defaults, window, fill count,
// found latch and both stage valids; config takes effect via config reg, then align reg
// depends on wbss_pkg, wbss_cfg, wbss_window, wbss_match
module wildcard_byte_signature_scanner_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [wbss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wbss_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_data_byte,
  input  logic [wbss_pkg::ADDR_BITS-1:0]        in_byte_address,
  input  logic                                  in_region_first,
  input  logic                                  in_scan_first,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_window_match,
  output logic                                  out_first_hit,
  output logic [wbss_pkg::ADDR_BITS-1:0]        out_hit_address
);

  wbss_pkg::align_t                                  align;
  wbss_pkg::stage_t                                  s1_stage;
  wbss_pkg::byte_t [wbss_pkg::MAX_PATTERN_BYTES-1:0] s1_window;
  logic                                              s1_valid;
  logic                                              advance;

  wbss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .align     (align)
  );

  wbss_window u_window (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_byte_address (in_byte_address),
    .in_region_first (in_region_first),
    .in_scan_first   (in_scan_first),
    .advance         (advance),
    .s1_valid        (s1_valid),
    .s1_stage        (s1_stage),
    .s1_window       (s1_window)
  );

  wbss_match u_match (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid),
    .s1_stage         (s1_stage),
    .s1_window        (s1_window),
    .align            (align),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_match (out_window_match),
    .out_first_hit    (out_first_hit),
    .out_hit_address  (out_hit_address)
  );

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for wildcard_byte_signature_scanner_top, random config phases
// and byte streams with pattern runs, per-field result compare against an in-bench predictor
// depends on wbss_pkg and the scanner rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [wbss_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [wbss_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 1200;

  typedef struct packed {
    logic                           window_match;
    logic                           first_hit;
    logic [wbss_pkg::ADDR_BITS-1:0] hit_address;
  } scan_result_t;

  class scan_scoreboard;
    logic [wbss_pkg::CFG_DATA_W-1:0] pattern_word [4];
    logic [31:0]                     care_mask;
    logic [5:0]                      pattern_len;
    wbss_pkg::byte_t                 window [wbss_pkg::MAX_PATTERN_BYTES];
    int unsigned                     fill;
    bit                              found;
    scan_result_t                    expected_results [$];
    int unsigned                     errors;

    function new();
      foreach (pattern_word[i]) pattern_word[i] = '0;
      foreach (window[i]) window[i] = '0;
      care_mask   = '0;
      pattern_len = 6'd1;
      fill        = 0;
      found       = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [wbss_pkg::CFG_IDX_W-1:0] idx,
                            logic [wbss_pkg::CFG_DATA_W-1:0] data);
      case (wbss_pkg::cfg_idx_t'(idx))
        wbss_pkg::CFG_PATTERN_0:      pattern_word[0] = data;
        wbss_pkg::CFG_PATTERN_1:      pattern_word[1] = data;
        wbss_pkg::CFG_PATTERN_2:      pattern_word[2] = data;
        wbss_pkg::CFG_PATTERN_3:      pattern_word[3] = data;
        wbss_pkg::CFG_CARE_MASK:      care_mask = data[31:0];
        wbss_pkg::CFG_PATTERN_LENGTH: pattern_len = data[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_len();
      int unsigned len;
      len = pattern_len;
      if (len == 0) len = 1;
      if (len > wbss_pkg::MAX_PATTERN_BYTES) len = wbss_pkg::MAX_PATTERN_BYTES;
      return len;
    endfunction

    function wbss_pkg::byte_t pattern_byte(int unsigned k);
      return pattern_word[k / 8][8 * (k % 8) +: 8];
    endfunction

    function void note_byte(wbss_pkg::byte_t d, logic [wbss_pkg::ADDR_BITS-1:0] a,
                            bit region_first, bit scan_first);
      int unsigned  len;
      bit           hit;
      scan_result_t res;
      len = eff_len();
      for (int i = wbss_pkg::MAX_PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = d;
      if (region_first) fill = 1;
      else if (fill < wbss_pkg::MAX_PATTERN_BYTES) fill++;
      if (scan_first) found = 1'b0;
      hit = (fill >= len);
      for (int unsigned k = 0; k < len; k++) begin
        if (care_mask[k] && window[len-1-k] != pattern_byte(k)) hit = 1'b0;
      end
      res.window_match = hit;
      res.first_hit    = hit && !found;
      res.hit_address  = hit ? a - wbss_pkg::ADDR_BITS'(len) + 1'b1 : '0;
      if (hit) found = 1'b1;
      expected_results = {expected_results, res};
    endfunction

    function void check(logic m, logic f, logic [wbss_pkg::ADDR_BITS-1:0] addr);
      scan_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, match %b first %b address %h", $time, m, f, addr);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (m !== e.window_match) begin
        $display("%0t: window_match expected %b actual %b", $time, e.window_match, m);
        errors++;
      end
      if (f !== e.first_hit) begin
        $display("%0t: first_hit expected %b actual %b", $time, e.first_hit, f);
        errors++;
      end
      if (addr !== e.hit_address) begin
        $display("%0t: hit_address expected %h actual %h", $time, e.hit_address, addr);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [wbss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wbss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [7:0]                      in_data_byte = '0;
  logic [wbss_pkg::ADDR_BITS-1:0]  in_byte_address = '0;
  logic                            in_region_first = 1'b0;
  logic                            in_scan_first = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_window_match;
  logic                            out_first_hit;
  logic [wbss_pkg::ADDR_BITS-1:0]  out_hit_address;

  scan_scoreboard                 sb = new();
  int unsigned                    items_sent = 0;
  logic [wbss_pkg::ADDR_BITS-1:0] next_addr = '0;
  bit                             no_idle = 1'b0;

  wildcard_byte_signature_scanner_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_byte_address  (in_byte_address),
    .in_region_first  (in_region_first),
    .in_scan_first    (in_scan_first),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_match (out_window_match),
    .out_first_hit    (out_first_hit),
    .out_hit_address  (out_hit_address)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input wbss_pkg::byte_t d, input logic [wbss_pkg::ADDR_BITS-1:0] a,
                           input bit rf, input bit sf, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= d;
    in_byte_address <= a;
    in_region_first <= rf;
    in_scan_first   <= sf;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_byte(d, a, rf, sf);
    items_sent++;
  endtask

  task automatic feed(input wbss_pkg::byte_t d, input bit start_region);
    bit rf;
    bit sf;
    rf = start_region || ($urandom_range(0, 49) == 0);
    sf = ($urandom_range(0, 39) == 0);
    if (rf && $urandom_range(0, 1) == 1) begin
      if ($urandom_range(0, 3) == 0)
        next_addr = '1 - wbss_pkg::ADDR_BITS'($urandom_range(0, 40));
      else
        next_addr = wbss_pkg::ADDR_BITS'({$urandom, $urandom});
    end
    send_byte(d, next_addr, rf, sf, pick_gap(no_idle));
    next_addr++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [wbss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wbss_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_close();
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // result side: random back-pressure and compare
  initial begin
    int stall_left;
    int burst_left;
    int r;
    stall_left = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready)
        sb.check(out_window_match, out_first_hit, out_hit_address);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (burst_left > 0) begin
        out_ready <= 1'b1;
        burst_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          stall_left = $urandom_range(10, 40);
          out_ready <= 1'b0;
        end else if (r < 20) begin
          stall_left = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else if (r < 24) begin
          burst_left = $urandom_range(40, 160);
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    wbss_pkg::byte_t d;
    int              elen;
    int              bad;
    int              junk;
    int              seqs;
    int              r;
    int unsigned     random_goal;
    logic [5:0]      len_sel;
    logic [31:0]     care_sel;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: length one, everything wildcard
    send_byte(8'h00, '0, 1'b1, 1'b1, 0);
    send_byte(8'hFF, '1, 1'b0, 1'b0, 0);
    send_byte(8'h3C, 48'h123, 1'b0, 1'b1, pick_gap(1'b0));
    drain();

    // length zero behaves as one, care bits past the length ignored
    cfg_write(wbss_pkg::CFG_PATTERN_0, 64'hDEAD_BEEF_CAFE_12A5);
    cfg_write(wbss_pkg::CFG_CARE_MASK, '1);
    cfg_write(wbss_pkg::CFG_PATTERN_LENGTH, '0);
    cfg_close();
    send_byte(8'hA5, 48'h5, 1'b1, 1'b1, 0);
    send_byte(8'h5A, 48'h6, 1'b0, 1'b0, 0);
    send_byte(8'hA5, 48'h7, 1'b0, 1'b0, 0);
    drain();

    // three bytes with a wildcard in the middle, address wrap, stale window
    cfg_write(wbss_pkg::CFG_PATTERN_0, 64'hFFFF_FFFF_FF33_2211);
    cfg_write(wbss_pkg::CFG_CARE_MASK, 64'hFFFF_FFFF_FFFF_FFFD);
    cfg_write(wbss_pkg::CFG_PATTERN_LENGTH, 64'd3);
    cfg_close();
    send_byte(8'h11, '1, 1'b1, 1'b1, 0);
    send_byte(8'h77, 48'h0, 1'b0, 1'b0, 0);
    send_byte(8'h33, 48'h1, 1'b0, 1'b0, 0);
    send_byte(8'h11, 48'hA, 1'b0, 1'b0, pick_gap(1'b0));
    send_byte(8'h22, 48'hB, 1'b1, 1'b0, 0);
    send_byte(8'h33, 48'hC, 1'b0, 1'b0, 0);
    send_byte(8'h11, 48'hD, 1'b0, 1'b0, 0);
    send_byte(8'h00, 48'hE, 1'b0, 1'b0, 0);
    send_byte(8'h33, 48'hF, 1'b0, 1'b1, 0);
    drain();

    // spare indexes ignored, oversize length saturates
    cfg_write(CFG_SPARE_A, {$urandom, $urandom});
    cfg_write(CFG_SPARE_B, {$urandom, $urandom});
    cfg_write(wbss_pkg::CFG_PATTERN_1, {$urandom, $urandom});
    cfg_write(wbss_pkg::CFG_PATTERN_2, {$urandom, $urandom});
    cfg_write(wbss_pkg::CFG_PATTERN_3, {$urandom, $urandom});
    cfg_write(wbss_pkg::CFG_CARE_MASK, '0);
    cfg_write(wbss_pkg::CFG_PATTERN_LENGTH, {$urandom, 26'($urandom), 6'd40});
    cfg_close();
    send_byte(8'h81, 48'h8000_0000_0000, 1'b1, 1'b1, 0);
    send_byte(8'h42, 48'h8000_0000_0001, 1'b0, 1'b0, 0);
    send_byte(8'hC3, 48'h8000_0000_0002, 1'b0, 1'b0, 0);
    drain();

    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      r = $urandom_range(0, 19);
      if (r == 0) len_sel = 6'd0;
      else if (r == 1) len_sel = 6'd32;
      else if (r == 2) len_sel = 6'($urandom_range(33, 63));
      else if (r < 6) len_sel = 6'($urandom_range(13, 31));
      else len_sel = 6'($urandom_range(1, 12));
      r = $urandom_range(0, 9);
      if (r == 0) care_sel = '0;
      else if (r == 1) care_sel = '1;
      else if (r < 4) care_sel = $urandom & $urandom;
      else care_sel = $urandom | $urandom;
      cfg_write(wbss_pkg::CFG_PATTERN_0, {$urandom, $urandom});
      cfg_write(wbss_pkg::CFG_PATTERN_1, {$urandom, $urandom});
      cfg_write(wbss_pkg::CFG_PATTERN_2, {$urandom, $urandom});
      cfg_write(wbss_pkg::CFG_PATTERN_3, {$urandom, $urandom});
      cfg_write(wbss_pkg::CFG_CARE_MASK, {$urandom, care_sel});
      cfg_write(wbss_pkg::CFG_PATTERN_LENGTH, {$urandom, 26'($urandom), len_sel});
      if ($urandom_range(0, 2) == 0)
        cfg_write(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  {$urandom, $urandom});
      cfg_close();
      no_idle = ($urandom_range(0, 3) == 0);
      elen = int'(sb.eff_len());
      seqs = $urandom_range(6, 14);
      for (int s = 0; s < seqs; s++) begin
        if ($urandom_range(0, 9) < 7) begin
          bad = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, elen - 1)) : -1;
          junk = $urandom_range(0, 3);
          for (int j = 0; j < junk; j++) feed(8'($urandom), 1'b0);
          for (int k = 0; k < elen; k++) begin
            d = sb.care_mask[k] ? sb.pattern_byte(k) : 8'($urandom);
            if (k == bad) d = d ^ 8'(1 << $urandom_range(0, 7));
            feed(d, k == 0 && $urandom_range(0, 4) == 0);
          end
        end else begin
          junk = $urandom_range(1, 8);
          for (int j = 0; j < junk; j++) feed(8'($urandom), 1'b0);
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/wbss_pkg.sv
rtl/wbss_cfg.sv
rtl/wbss_window.sv
rtl/wbss_match.sv
rtl/wildcard_byte_signature_scanner_top.sv
sim/tb_top.sv
